// ----- rtl/core/nfca_pkg.sv -----
// Shared definitions for the NFC-A anticollision sequencer: phase type, codes,
// frame constants, stream widths and the single-byte CRC_A function.
// Depends on nothing; every other file of the block imports it.
package nfca_pkg;

	// Default sizing of the UID store and of the cascade depth.
	localparam int UID_MAX_BYTES_DEF = 10;
	localparam int MAX_LEVELS_DEF    = 3;

	// Stream widths: input tdata holds 43 field bits, output tdata holds 75.
	localparam int IN_DATA_W  = 48;
	localparam int IN_USER_W  = 1;
	localparam int OUT_DATA_W = 80;
	localparam int OUT_USER_W = 2;

	// Sequencer phase.
	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_ATQA = 2'd1,
		PH_ANTI = 2'd2,
		PH_SAK  = 2'd3
	} phase_t;

	// Input command codes.
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_REPLY = 1'b1;

	// Transfer status codes; any other value counts as a collision.
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_TX_ERROR   = 3'd1;
	localparam logic [2:0] ST_TX_TIMEOUT = 3'd2;
	localparam logic [2:0] ST_RX_TIMEOUT = 3'd3;

	// Result kinds.
	localparam logic [1:0] KIND_FRAME   = 2'd0;
	localparam logic [1:0] KIND_UID     = 2'd1;
	localparam logic [1:0] KIND_OUTCOME = 2'd2;

	// Outcome codes.
	localparam logic [3:0] OC_SUCCESS    = 4'd0;
	localparam logic [3:0] OC_TX_FAIL    = 4'd1;
	localparam logic [3:0] OC_NO_TAG     = 4'd2;
	localparam logic [3:0] OC_RX_TIMEOUT = 4'd3;
	localparam logic [3:0] OC_COLLISION  = 4'd4;
	localparam logic [3:0] OC_BCC        = 4'd5;
	localparam logic [3:0] OC_CRC        = 4'd6;
	localparam logic [3:0] OC_INCOMPLETE = 4'd7;
	localparam logic [3:0] OC_NOT_L4     = 4'd8;

	// Frame constants of ISO/IEC 14443-3 type A.
	localparam logic [7:0]  REQA_CMD      = 8'h26;
	localparam logic [2:0]  REQA_BITS     = 3'd7;
	localparam logic [7:0]  SEL_CL1       = 8'h93;
	localparam logic [7:0]  NVB_ANTICOLL  = 8'h20;
	localparam logic [7:0]  NVB_SELECT    = 8'h70;
	localparam logic [2:0]  LEN_REQA      = 3'd1;
	localparam logic [2:0]  LEN_ANTICOLL  = 3'd2;
	localparam logic [2:0]  LEN_SELECT    = 3'd7;
	localparam logic [15:0] CRC_A_PRESET  = 16'h6363;

	// SAK bits: cascade bit and level-4 compliance bit.
	localparam int SAK_CASCADE_BIT = 2;
	localparam int SAK_L4_BIT      = 5;

	// CRC_A over one byte starting from the preset.
	function automatic logic [15:0] crc_a_byte(input logic [7:0] b);
		logic [7:0] ch;
		ch = b ^ CRC_A_PRESET[7:0];
		ch = ch ^ {ch[3:0], 4'b0000};
		return {8'h00, CRC_A_PRESET[15:8]} ^ {ch, 8'h00} ^ {5'b00000, ch, 3'b000}
			^ {12'h000, ch[7:4]};
	endfunction

endpackage

// ----- rtl/core/nfca_anticollision_sequencer.sv -----
// Top level of the NFC-A anticollision and select sequencer.
// Depends on nfca_pkg for codes, frame constants, widths and the CRC_A function.
//
// The block drives a type A reader through REQA, then per cascade level an
// anticollision frame and a select frame (UID part, BCC, CRC appended), checks
// the BCC of each anticollision reply and the CRC_A of each SAK, and finally
// streams the assembled UID bytes followed by one outcome code. Every input
// transfer passes an input register and is evaluated by combinational
// logic that updates the phase and loads the output sequencer; the output
// sequencer then presents one result per cycle while the output side is
// ready. An item that causes one result (frame or outcome) is taken every
// cycle when the output side is ready; a final SAK reply occupies the output
// sequencer until its UID bytes and its outcome are transferred, and the next
// item is evaluated in the cycle the last result is transferred. A reply
// while idle causes no result. The UID store needs no clearing after reset.
module nfca_anticollision_sequencer #(
	parameter int UID_MAX_BYTES = nfca_pkg::UID_MAX_BYTES_DEF,
	parameter int MAX_LEVELS    = nfca_pkg::MAX_LEVELS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// From bit 0: xfer_status[2:0], reply_bytes[42:3], zero fill[47:43].
	input  logic [nfca_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// From bit 0: cmd[0].
	input  logic [nfca_pkg::IN_USER_W-1:0]  s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// From bit 0: frame_data[55:0], frame_len[58:56], last_byte_bits[61:59],
	// append_crc[62], uid_byte[70:63], outcome[74:71], zero fill[79:75].
	output logic [nfca_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// From bit 0: kind[1:0].
	output logic [nfca_pkg::OUT_USER_W-1:0] m_axis_tuser,
	output logic                            m_axis_tlast
);
	import nfca_pkg::*;

	localparam int CNT_W = $clog2(UID_MAX_BYTES + 1);
	localparam int IDX_W = $clog2(UID_MAX_BYTES);
	localparam logic [CNT_W:0] UID_MAX_C  = (CNT_W + 1)'(UID_MAX_BYTES);
	localparam logic [1:0]     LAST_LEVEL = 2'(MAX_LEVELS - 1);

	// Input register.
	logic        in_valid_s1;
	logic        cmd_s1;
	logic [2:0]  status_s1;
	logic [39:0] bytes_s1;

	// Sequence state.
	phase_t             phase_q, phase_d;
	logic [1:0]         level_q, level_d;
	logic [31:0]        level_uid_q, level_uid_d;
	logic [CNT_W-1:0]   uid_count_q, uid_count_d;
	logic [7:0]         uid_store_q [UID_MAX_BYTES];
	logic               store_we [UID_MAX_BYTES];
	logic [7:0]         store_wd [UID_MAX_BYTES];

	// Output sequencer.
	logic               busy_q;
	logic               emit_frame_q;
	logic [55:0]        frame_data_q;
	logic [2:0]         frame_len_q;
	logic [2:0]         frame_bits_q;
	logic               frame_crc_q;
	logic [CNT_W-1:0]   uid_idx_q;
	logic [CNT_W-1:0]   uid_num_q;
	logic [3:0]         outcome_q;

	// Result descriptor built during evaluation.
	logic               res_valid;
	logic               res_frame;
	logic [55:0]        res_data;
	logic [2:0]         res_len;
	logic [2:0]         res_bits;
	logic               res_crc;
	logic [CNT_W-1:0]   res_uid_num;
	logic [3:0]         res_outcome;

	logic               uid_beat, beat_last, out_hs, emit_free, proc, in_hs;
	logic               st_ok, st_tx_fail, st_rx_to;
	logic [3:0]         fault_code;
	logic [7:0]         bcc_calc, sak, sel_code;
	logic               bcc_ok, crc_ok, sak_cascade, sak_l4, at_last_level;
	logic               store_wr, store_skip;
	logic [CNT_W:0]     count_sum;
	logic [CNT_W-1:0]   count_new;
	logic [7:0]         uid_rd;
	logic [1:0]         beat_kind;

	// Handshake and flow between the input register and the output sequencer.
	assign uid_beat      = !emit_frame_q && (uid_idx_q < uid_num_q);
	assign beat_last     = !uid_beat;
	assign out_hs        = busy_q && m_axis_tready;
	assign emit_free     = !busy_q || (out_hs && beat_last);
	assign proc          = in_valid_s1 && emit_free;
	assign s_axis_tready = !in_valid_s1 || emit_free;
	assign in_hs         = s_axis_tvalid && s_axis_tready;

	// Status decoding.
	assign st_ok      = (status_s1 == ST_OK);
	assign st_tx_fail = (status_s1 == ST_TX_ERROR) || (status_s1 == ST_TX_TIMEOUT);
	assign st_rx_to   = (status_s1 == ST_RX_TIMEOUT);
	assign fault_code = st_tx_fail ? OC_TX_FAIL : (st_rx_to ? OC_RX_TIMEOUT : OC_COLLISION);

	// Reply checks.
	assign bcc_calc      = bytes_s1[7:0] ^ bytes_s1[15:8] ^ bytes_s1[23:16] ^ bytes_s1[31:24];
	assign bcc_ok        = (bcc_calc == bytes_s1[39:32]);
	assign sak           = bytes_s1[7:0];
	assign crc_ok        = (bytes_s1[23:8] == crc_a_byte(sak));
	assign sak_cascade   = sak[SAK_CASCADE_BIT];
	assign sak_l4        = sak[SAK_L4_BIT];
	assign sel_code      = SEL_CL1 + {5'b00000, level_q, 1'b0};
	assign at_last_level = (level_q >= LAST_LEVEL);

	// UID append on a good SAK: four bytes, or three after the cascade tag.
	assign store_wr   = proc && (cmd_s1 == CMD_REPLY) && (phase_q == PH_SAK) && st_ok && crc_ok;
	assign store_skip = sak_cascade;
	assign count_sum  = {1'b0, uid_count_q} + (store_skip ? (CNT_W + 1)'(3) : (CNT_W + 1)'(4));
	assign count_new  = (count_sum > UID_MAX_C) ? UID_MAX_C[CNT_W-1:0] : count_sum[CNT_W-1:0];

	always_comb begin
		for (int e = 0; e < UID_MAX_BYTES; e++) begin
			store_we[e] = 1'b0;
			store_wd[e] = 8'h00;
			for (int s = 0; s < 4; s++) begin
				if (store_wr && (s >= int'(store_skip))
						&& (int'(uid_count_q) + s - int'(store_skip) == e)) begin
					store_we[e] = 1'b1;
					store_wd[e] = level_uid_q[8*s +: 8];
				end
			end
		end
	end

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		if (proc) begin
			if (cmd_s1 == CMD_START) begin
				phase_d = PH_ATQA;
			end else begin
				unique case (phase_q)
					PH_IDLE: phase_d = PH_IDLE;
					PH_ATQA: phase_d = (st_tx_fail || st_rx_to) ? PH_IDLE : PH_ANTI;
					PH_ANTI: phase_d = (!st_ok || !bcc_ok) ? PH_IDLE : PH_SAK;
					PH_SAK: begin
						if (!st_ok || !crc_ok || !sak_cascade || at_last_level) begin
							phase_d = PH_IDLE;
						end else begin
							phase_d = PH_ANTI;
						end
					end
				endcase
			end
		end
	end

	// Results and data state of one evaluation.
	always_comb begin
		res_valid   = 1'b0;
		res_frame   = 1'b0;
		res_data    = '0;
		res_len     = '0;
		res_bits    = '0;
		res_crc     = 1'b0;
		res_uid_num = '0;
		res_outcome = OC_SUCCESS;
		level_d     = level_q;
		level_uid_d = level_uid_q;
		uid_count_d = uid_count_q;
		if (proc) begin
			if (cmd_s1 == CMD_START) begin
				level_d     = 2'd0;
				level_uid_d = '0;
				uid_count_d = '0;
				res_valid   = 1'b1;
				res_frame   = 1'b1;
				res_data    = {48'h0, REQA_CMD};
				res_len     = LEN_REQA;
				res_bits    = REQA_BITS;
			end else begin
				unique case (phase_q)
					PH_IDLE: res_valid = 1'b0;
					PH_ATQA: begin
						res_valid = 1'b1;
						if (st_tx_fail) begin
							res_outcome = OC_TX_FAIL;
						end else if (st_rx_to) begin
							res_outcome = OC_NO_TAG;
						end else begin
							res_frame = 1'b1;
							res_data  = {40'h0, NVB_ANTICOLL, sel_code};
							res_len   = LEN_ANTICOLL;
						end
					end
					PH_ANTI: begin
						res_valid = 1'b1;
						if (!st_ok) begin
							res_outcome = fault_code;
						end else if (!bcc_ok) begin
							res_outcome = OC_BCC;
						end else begin
							level_uid_d = bytes_s1[31:0];
							res_frame   = 1'b1;
							res_data    = {bcc_calc, bytes_s1[31:0], NVB_SELECT, sel_code};
							res_len     = LEN_SELECT;
							res_crc     = 1'b1;
						end
					end
					PH_SAK: begin
						res_valid = 1'b1;
						if (!st_ok) begin
							res_outcome = fault_code;
						end else if (!crc_ok) begin
							res_outcome = OC_CRC;
						end else begin
							uid_count_d = count_new;
							if (!sak_cascade) begin
								res_uid_num = count_new;
								res_outcome = sak_l4 ? OC_SUCCESS : OC_NOT_L4;
							end else if (at_last_level) begin
								res_outcome = OC_INCOMPLETE;
							end else begin
								level_d   = level_q + 2'd1;
								res_frame = 1'b1;
								res_data  = {40'h0, NVB_ANTICOLL, sel_code + 8'd2};
								res_len   = LEN_ANTICOLL;
							end
						end
					end
				endcase
			end
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_hs) begin
			in_valid_s1 <= 1'b1;
		end else if (proc) begin
			in_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_hs) begin
			cmd_s1    <= s_axis_tuser[0];
			status_s1 <= s_axis_tdata[2:0];
			bytes_s1  <= s_axis_tdata[42:3];
		end
	end

	// Sequence state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			level_q     <= 2'd0;
			level_uid_q <= '0;
			uid_count_q <= '0;
		end else begin
			phase_q     <= phase_d;
			level_q     <= level_d;
			level_uid_q <= level_uid_d;
			uid_count_q <= uid_count_d;
		end
	end

	// UID store, written per entry.
	always_ff @(posedge clk) begin
		for (int e = 0; e < UID_MAX_BYTES; e++) begin
			if (store_we[e]) begin
				uid_store_q[e] <= store_wd[e];
			end
		end
	end

	// Output sequencer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			uid_idx_q <= '0;
		end else if (proc && res_valid) begin
			busy_q    <= 1'b1;
			uid_idx_q <= '0;
		end else if (emit_free) begin
			busy_q    <= 1'b0;
		end else if (out_hs) begin
			uid_idx_q <= uid_idx_q + 1'b1;
		end
	end

	// Output sequencer payload.
	always_ff @(posedge clk) begin
		if (proc && res_valid) begin
			emit_frame_q <= res_frame;
			frame_data_q <= res_data;
			frame_len_q  <= res_len;
			frame_bits_q <= res_bits;
			frame_crc_q  <= res_crc;
			uid_num_q    <= res_uid_num;
			outcome_q    <= res_outcome;
		end
	end

	// Present the current result.
	assign uid_rd    = uid_store_q[uid_idx_q[IDX_W-1:0]];
	assign beat_kind = emit_frame_q ? KIND_FRAME : (uid_beat ? KIND_UID : KIND_OUTCOME);

	assign m_axis_tvalid = busy_q;
	assign m_axis_tuser  = beat_kind;
	assign m_axis_tlast  = beat_last;
	assign m_axis_tdata  = {
		5'b00000,
		(beat_kind == KIND_OUTCOME) ? outcome_q : 4'h0,
		(beat_kind == KIND_UID) ? uid_rd : 8'h00,
		emit_frame_q ? frame_crc_q : 1'b0,
		emit_frame_q ? frame_bits_q : 3'd0,
		emit_frame_q ? frame_len_q : 3'd0,
		emit_frame_q ? frame_data_q : 56'h0
	};

endmodule

// ----- rtl/core/nfca_chk.sv -----
// Port-level checker for the NFC-A anticollision sequencer, bound to its top.
// Depends on nfca_pkg for widths and result kind codes.
module nfca_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [nfca_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic [nfca_pkg::OUT_USER_W-1:0] m_axis_tuser,
	input logic                            m_axis_tlast
);
	import nfca_pkg::*;

	// A stalled result holds its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("stalled result changed");

	// UID bytes are always followed by the outcome, so never close a burst.
	a_uid_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == KIND_UID) |-> !m_axis_tlast)
		else $error("UID byte marked last");

	// Frames and outcomes end the results of their item.
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && ((m_axis_tuser == KIND_FRAME) || (m_axis_tuser == KIND_OUTCOME))
			|-> m_axis_tlast)
		else $error("frame or outcome not marked last");

	// Frame fields are zero on results that are not frames.
	a_frame_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != KIND_FRAME) |-> (m_axis_tdata[62:0] == 63'h0))
		else $error("frame fields set on a non-frame result");

endmodule

bind nfca_anticollision_sequencer nfca_chk u_nfca_chk (.*);

// ----- verif/tb_nfca_anticollision_sequencer.sv -----
// Testbench for the NFC-A anticollision sequencer: random and directed scans on
// the input stream, with a cycle-free predictor checking every output transfer.
// Depends on nfca_pkg and the nfca_anticollision_sequencer top level.
`timescale 1ns / 1ps

module tb_nfca_anticollision_sequencer;
	import nfca_pkg::*;

	localparam logic [2:0]  ST_COLLISION    = 3'd4;
	localparam logic [15:0] CRC_A_POLY_REFL = 16'h8408;
	localparam int          RANDOM_ITEMS    = 260;
	localparam int          HOLD_AT_ITEM    = 80;
	localparam int          HOLD_CYCLES     = 300;
	localparam int          CALM_FROM       = 150;
	localparam int          CALM_TO         = 230;
	localparam int          IDLE_PERCENT    = 19;
	localparam int          DRAIN_CYCLES    = 40;
	localparam int          STALL_LIMIT     = 2000;

	// One reader event as offered on the input stream.
	typedef struct packed {
		logic        cmd;
		logic [2:0]  st;
		logic [39:0] rb;
	} reader_item_t;

	// One sequencer result, as carried by the output stream.
	typedef struct packed {
		logic [1:0]  kind;
		logic [55:0] frame_data;
		logic [2:0]  frame_len;
		logic [2:0]  last_byte_bits;
		logic        append_crc;
		logic [7:0]  uid_byte;
		logic [3:0]  outcome;
		logic        last;
	} seq_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [IN_USER_W-1:0]  s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [OUT_USER_W-1:0] m_axis_tuser;
	logic                  m_axis_tlast;

	reader_item_t reader_items_q[$];
	seq_result_t  results_due_q[$];
	int           items_in = 0;
	int           mismatches = 0;
	int           scan_items = 0;
	int           item_results;

	// Predictor state of the card scan.
	phase_t       scan_phase = PH_IDLE;
	logic [1:0]   level_idx = '0;
	logic [31:0]  level_uid_q = '0;
	logic [7:0]   uid_mem [UID_MAX_BYTES_DEF];
	int           uid_len = 0;

	nfca_anticollision_sequencer u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #1 clk = ~clk;

	// Bit-serial CRC_A over one byte, least significant bit first.
	function automatic logic [15:0] crc_a_of(input logic [7:0] b);
		logic [15:0] c;
		c = CRC_A_PRESET;
		for (int k = 0; k < 8; k++) begin
			if (c[0] ^ b[k])
				c = (c >> 1) ^ CRC_A_POLY_REFL;
			else
				c = c >> 1;
		end
		return c;
	endfunction

	// Status of a transfer mapped to its outcome once past the REQA stage.
	function automatic logic [3:0] status_fault(input logic [2:0] st);
		case (st)
			ST_OK:         return OC_SUCCESS;
			ST_TX_ERROR,
			ST_TX_TIMEOUT: return OC_TX_FAIL;
			ST_RX_TIMEOUT: return OC_RX_TIMEOUT;
			default:       return OC_COLLISION;
		endcase
	endfunction

	// Anticollision reply: four UID bytes followed by their XOR check byte.
	function automatic logic [39:0] anticoll_reply(input logic [31:0] uid);
		return {uid[7:0] ^ uid[15:8] ^ uid[23:16] ^ uid[31:24], uid};
	endfunction

	// SAK reply with a correct CRC and random trailing bytes.
	function automatic logic [39:0] sak_reply(input logic [7:0] sak);
		logic [15:0] pad;
		pad = 16'($urandom());
		return {pad, crc_a_of(sak), sak};
	endfunction

	task automatic add_item(input logic cmd, input logic [2:0] st, input logic [39:0] rb,
			input bit counted);
		reader_items_q.push_back('{cmd: cmd, st: st, rb: rb});
		if (counted)
			scan_items++;
	endtask

	task automatic due_frame(input logic [55:0] data, input logic [2:0] len,
			input logic [2:0] bits, input logic crc);
		results_due_q.push_back('{kind: KIND_FRAME, frame_data: data, frame_len: len,
			last_byte_bits: bits, append_crc: crc, default: '0});
		item_results++;
	endtask

	task automatic due_uid(input logic [7:0] b);
		results_due_q.push_back('{kind: KIND_UID, uid_byte: b, default: '0});
		item_results++;
	endtask

	task automatic due_outcome(input logic [3:0] code);
		results_due_q.push_back('{kind: KIND_OUTCOME, outcome: code, default: '0});
		item_results++;
		scan_phase = PH_IDLE;
	endtask

	task automatic due_anticoll();
		due_frame({40'h0, NVB_ANTICOLL, SEL_CL1 + {5'b0, level_idx, 1'b0}},
			LEN_ANTICOLL, 3'd0, 1'b0);
		scan_phase = PH_ANTI;
	endtask

	task automatic keep_uid_byte(input logic [7:0] b);
		if (uid_len < UID_MAX_BYTES_DEF) begin
			uid_mem[uid_len] = b;
			uid_len++;
		end
	endtask

	// Works out every result that one accepted reader event causes.
	task automatic scan_predict(input reader_item_t it);
		logic [7:0] bcc;
		logic [7:0] sak;
		logic [3:0] fault;
		item_results = 0;
		if (it.cmd == CMD_START) begin
			level_idx = '0;
			level_uid_q = '0;
			uid_len = 0;
			due_frame({48'h0, REQA_CMD}, LEN_REQA, REQA_BITS, 1'b0);
			scan_phase = PH_ATQA;
		end else begin
			case (scan_phase)
				PH_ATQA: begin
					// A collision on the ATQA is harmless: the scan goes on.
					if (it.st == ST_TX_ERROR || it.st == ST_TX_TIMEOUT)
						due_outcome(OC_TX_FAIL);
					else if (it.st == ST_RX_TIMEOUT)
						due_outcome(OC_NO_TAG);
					else
						due_anticoll();
				end
				PH_ANTI: begin
					fault = status_fault(it.st);
					bcc = it.rb[7:0] ^ it.rb[15:8] ^ it.rb[23:16] ^ it.rb[31:24];
					if (fault != OC_SUCCESS) begin
						due_outcome(fault);
					end else if (bcc != it.rb[39:32]) begin
						due_outcome(OC_BCC);
					end else begin
						level_uid_q = it.rb[31:0];
						due_frame({bcc, level_uid_q, NVB_SELECT,
							SEL_CL1 + {5'b0, level_idx, 1'b0}}, LEN_SELECT, 3'd0, 1'b1);
						scan_phase = PH_SAK;
					end
				end
				PH_SAK: begin
					fault = status_fault(it.st);
					sak = it.rb[7:0];
					if (fault != OC_SUCCESS) begin
						due_outcome(fault);
					end else if (it.rb[23:8] != crc_a_of(sak)) begin
						due_outcome(OC_CRC);
					end else if (!sak[SAK_CASCADE_BIT]) begin
						// UID complete: all four bytes of this level count.
						for (int i = 0; i < 4; i++)
							keep_uid_byte(level_uid_q[8*i +: 8]);
						for (int i = 0; i < uid_len; i++)
							due_uid(uid_mem[i]);
						due_outcome(sak[SAK_L4_BIT] ? OC_SUCCESS : OC_NOT_L4);
					end else begin
						// Cascade tag in the first byte is dropped.
						for (int i = 1; i < 4; i++)
							keep_uid_byte(level_uid_q[8*i +: 8]);
						if (int'(level_idx) + 1 >= MAX_LEVELS_DEF) begin
							due_outcome(OC_INCOMPLETE);
						end else begin
							level_idx = level_idx + 2'd1;
							due_anticoll();
						end
					end
				end
				default: ;
			endcase
		end
		if (item_results > 0)
			results_due_q[results_due_q.size() - 1].last = 1'b1;
	endtask

	// Input driver: offers queued reader events, idling at random.
	always @(posedge clk or negedge arst_n) begin : drive_blk
		reader_item_t nxt;
		bit           calm;
		bit           offer;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			calm  = (items_in >= CALM_FROM && items_in < CALM_TO);
			offer = calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
			if (reader_items_q.size() > 0 && offer) begin
				nxt = reader_items_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= {{(IN_DATA_W - 43){1'b0}}, nxt.rb, nxt.st};
				s_axis_tuser  <= nxt.cmd;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Output receiver: random back-pressure plus one long hold-off.
	always @(posedge clk or negedge arst_n) begin : sink_blk
		int hold_left;
		bit hold_done;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_left = 0;
			hold_done = 0;
		end else begin
			if (!hold_done && items_in >= HOLD_AT_ITEM) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (items_in >= CALM_FROM && items_in < CALM_TO) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
			end
		end
	end

	// Monitor: predicts on each input transfer, checks each output transfer.
	always @(posedge clk) begin : check_blk
		seq_result_t got;
		seq_result_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				items_in++;
				scan_predict('{cmd: s_axis_tuser[0], st: s_axis_tdata[2:0],
					rb: s_axis_tdata[42:3]});
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{kind: m_axis_tuser[1:0], frame_data: m_axis_tdata[55:0],
					frame_len: m_axis_tdata[58:56], last_byte_bits: m_axis_tdata[61:59],
					append_crc: m_axis_tdata[62], uid_byte: m_axis_tdata[70:63],
					outcome: m_axis_tdata[74:71], last: m_axis_tlast};
				if (results_due_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: kind %0d data %h outcome %0d",
							got.kind, got.frame_data, got.outcome);
				end else begin
					want = results_due_q.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: kind %0d/%0d data %h/%h len %0d/%0d",
								" bits %0d/%0d crc %0d/%0d uid %h/%h outcome %0d/%0d",
								" last %0d/%0d (expected/actual)"},
								want.kind, got.kind, want.frame_data, got.frame_data,
								want.frame_len, got.frame_len, want.last_byte_bits,
								got.last_byte_bits, want.append_crc, got.append_crc,
								want.uid_byte, got.uid_byte, want.outcome, got.outcome,
								want.last, got.last);
					end
				end
			end
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin : watchdog_blk
		int quiet;
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= STALL_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin : stim_blk
		logic [63:0] r64;
		logic [31:0] uid;
		logic [7:0]  sak;
		logic [39:0] rb;
		int          roll;
		int          levels;
		int          pick;
		bit          alive;

		// Directed: reply while idle, no tag, tx error, collision on ATQA, then a one-level UID.
		add_item(CMD_REPLY, ST_OK, '1, 1'b0);
		add_item(CMD_START, 3'd7, '1, 1'b1);
		add_item(CMD_REPLY, ST_RX_TIMEOUT, '0, 1'b1);
		add_item(CMD_START, ST_OK, '0, 1'b1);
		add_item(CMD_REPLY, ST_TX_ERROR, '1, 1'b1);
		add_item(CMD_START, ST_OK, '0, 1'b1);
		add_item(CMD_REPLY, ST_COLLISION, '0, 1'b1);
		add_item(CMD_REPLY, ST_OK, anticoll_reply(32'hFFFF_FFFF), 1'b1);
		add_item(CMD_REPLY, ST_OK, sak_reply(8'h20), 1'b1);
		// Undefined status on ATQA goes on; then a broken check byte.
		add_item(CMD_START, ST_OK, '0, 1'b1);
		add_item(CMD_REPLY, 3'd7, '1, 1'b1);
		add_item(CMD_REPLY, ST_OK, 40'h01_1234_5678, 1'b1);
		// Bad CRC on the SAK.
		add_item(CMD_START, ST_OK, '0, 1'b1);
		add_item(CMD_REPLY, ST_OK, '0, 1'b1);
		add_item(CMD_REPLY, ST_OK, anticoll_reply(32'h0), 1'b1);
		add_item(CMD_REPLY, ST_OK, {16'h0, ~crc_a_of(8'h20), 8'h20}, 1'b1);
		// Full ten-byte UID over three levels, not level-4 compliant.
		add_item(CMD_START, ST_OK, '0, 1'b1);
		add_item(CMD_REPLY, ST_OK, '0, 1'b1);
		add_item(CMD_REPLY, ST_OK, anticoll_reply(32'h8844_2288), 1'b1);
		add_item(CMD_REPLY, ST_OK, sak_reply(8'h04), 1'b1);
		add_item(CMD_REPLY, ST_OK, anticoll_reply(32'h7711_3388), 1'b1);
		add_item(CMD_REPLY, ST_OK, sak_reply(8'h24), 1'b1);
		add_item(CMD_REPLY, ST_OK, anticoll_reply(32'hA55A_C33C), 1'b1);
		add_item(CMD_REPLY, ST_OK, sak_reply(8'h00), 1'b1);

		// Random: mostly well-formed scans with faults sprinkled in, some noise.
		while (scan_items < RANDOM_ITEMS) begin
			roll = $urandom_range(0, 99);
			r64 = {$urandom(), $urandom()};
			if (roll < 15) begin
				add_item(r64[63], r64[62:60], r64[39:0], 1'b1);
			end else begin
				alive = 1;
				add_item(CMD_START, r64[62:60], r64[39:0], 1'b1);
				r64 = {$urandom(), $urandom()};
				if ($urandom_range(0, 99) < 10) begin
					add_item(CMD_REPLY, 3'($urandom_range(1, 3)), r64[39:0], 1'b1);
					alive = 0;
				end else begin
					pick = $urandom_range(0, 4);
					add_item(CMD_REPLY, (pick == 0) ? ST_OK : 3'(pick + 3), r64[39:0], 1'b1);
				end
				levels = $urandom_range(1, 4);
				for (int lvl = 1; lvl <= 3 && lvl <= levels && alive; lvl++) begin
					uid = $urandom();
					r64 = {$urandom(), $urandom()};
					roll = $urandom_range(0, 99);
					if (roll < 4) begin
						add_item(CMD_REPLY, 3'($urandom_range(1, 7)), r64[39:0], 1'b1);
						alive = 0;
					end else if (roll < 7) begin
						rb = anticoll_reply(uid);
						rb[39:32] = rb[39:32] ^ 8'($urandom_range(1, 255));
						add_item(CMD_REPLY, ST_OK, rb, 1'b1);
						alive = 0;
					end else if (roll < 9) begin
						// Start in mid-scan abandons it.
						add_item(CMD_START, r64[62:60], r64[39:0], 1'b1);
						alive = 0;
					end else begin
						add_item(CMD_REPLY, ST_OK, anticoll_reply(uid), 1'b1);
					end
					if (alive) begin
						sak = 8'($urandom());
						sak[SAK_CASCADE_BIT] = (lvl < levels);
						roll = $urandom_range(0, 99);
						if (roll < 4) begin
							add_item(CMD_REPLY, 3'($urandom_range(1, 7)), r64[39:0], 1'b1);
							alive = 0;
						end else if (roll < 7) begin
							rb = sak_reply(sak);
							rb[23:8] = rb[23:8] ^ 16'($urandom_range(1, 65535));
							add_item(CMD_REPLY, ST_OK, rb, 1'b1);
							alive = 0;
						end else begin
							add_item(CMD_REPLY, ST_OK, sak_reply(sak), 1'b1);
						end
					end
				end
				// Occasional stray reply after the scan has ended.
				if ($urandom_range(0, 3) == 0) begin
					r64 = {$urandom(), $urandom()};
					add_item(CMD_REPLY, r64[62:60], r64[39:0], 1'b0);
				end
			end
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (reader_items_q.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		while (results_due_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (results_due_q.size() != 0) begin
			$display("%0d expected results never arrived", results_due_q.size());
			mismatches += results_due_q.size();
		end
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
